// File: rtl/pixel_to_hex_cell_locator_macros.svh
// Assertion macros shared by the locator RTL.
`ifndef PIXEL_TO_HEX_CELL_LOCATOR_MACROS_SVH
`define PIXEL_TO_HEX_CELL_LOCATOR_MACROS_SVH

// Concurrent assertion of any property, sampled on clk, off while arst_n is low.
`define P2H_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Next-cycle implication.
`define P2H_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) pre |=> post) else $error(msg);

`endif

// File: rtl/p2h_pkg.sv
// Shared types and fixed constants of the hex cell locator.
`default_nettype none

package p2h_pkg;

	localparam int PT_W   = 12;   // pixel coordinate width
	localparam int IDX_W  = 10;   // reported column / row width
	localparam int RCP_SH = 24;   // fraction bits of the reciprocal multipliers

	typedef logic [PT_W-1:0]  pt_t;
	typedef logic [IDX_W-1:0] idx_t;

endpackage

`default_nettype wire

// File: rtl/p2h_cdiv.sv
// Two-stage divider of a pixel coordinate by a fixed divisor (reciprocal multiply).
`default_nettype none

module p2h_cdiv import p2h_pkg::*; #(
	parameter int DIVISOR = 3,
	parameter int Q_W     = 11
) (
	input  logic           clk,
	input  pt_t            num,
	output logic [Q_W-1:0] quo
);

	localparam int PW = PT_W + RCP_SH;
	localparam logic [RCP_SH-1:0] RECIP = RCP_SH'((64'd1 << RCP_SH) / DIVISOR);

	logic [PW-1:0]  prod;
	pt_t            num_s2;
	logic [Q_W-1:0] est_s2;
	pt_t            rem;
	logic [Q_W-1:0] q_s3;

	// floor reciprocal: estimate is exact or one low
	assign prod = PW'(num) * PW'(RECIP);

	always_ff @(posedge clk) begin
		num_s2 <= num;
		est_s2 <= Q_W'(prod >> RCP_SH);
	end

	assign rem = num_s2 - PT_W'(PT_W'(est_s2) * PT_W'(DIVISOR));

	always_ff @(posedge clk) begin
		q_s3 <= (rem >= PT_W'(DIVISOR)) ? est_s2 + 1'b1 : est_s2;
	end

	assign quo = q_s3;

endmodule

`default_nettype wire

// File: rtl/p2h_guess.sv
// Guessed column and doubled row from the grid pitches.
`default_nettype none

module p2h_guess import p2h_pkg::*; #(
	parameter int SIDE_LEN    = 20,
	parameter int SLANT_WIDTH = 10,
	parameter int COL_PITCH   = 32,
	parameter int ROW_PITCH   = 36,
	parameter int Y_OFS       = 19,
	parameter int CW          = 8,
	parameter int QY          = 7
) (
	input  logic          clk,
	input  pt_t           px,
	input  pt_t           py,
	output logic [CW-1:0] gc,
	output logic [QY:0]   gr
);

	pt_t            nx;
	pt_t            ny;
	logic [QY-1:0]  qe;
	logic [QY-1:0]  qo;

	// left margin maps to column 0; low odd rows clamp to row 1
	assign nx = (px < PT_W'(SIDE_LEN + SLANT_WIDTH)) ? '0 : px - PT_W'(SLANT_WIDTH);
	assign ny = (py < PT_W'(Y_OFS)) ? '0 : py - PT_W'(Y_OFS);

	p2h_cdiv #(.DIVISOR(COL_PITCH), .Q_W(CW)) u_div_x (
		.clk (clk),
		.num (nx),
		.quo (gc)
	);

	p2h_cdiv #(.DIVISOR(ROW_PITCH), .Q_W(QY)) u_div_ye (
		.clk (clk),
		.num (py),
		.quo (qe)
	);

	p2h_cdiv #(.DIVISOR(ROW_PITCH), .Q_W(QY)) u_div_yo (
		.clk (clk),
		.num (ny),
		.quo (qo)
	);

	assign gr = gc[0] ? {qo, 1'b1} : {qe, 1'b0};

endmodule

`default_nettype wire

// File: rtl/p2h_cand.sv
// Containment test of one candidate hexagon, two register stages.
`default_nettype none

module p2h_cand import p2h_pkg::*; #(
	parameter int SIDE_LEN    = 20,
	parameter int SLANT_WIDTH = 10,
	parameter int CELL_HEIGHT = 34,
	parameter int GAP_X       = 2,
	parameter int CELL_WIDTH  = 40,
	parameter int PAIR_PITCH  = 64,
	parameter int ROW_STEP    = 18,
	parameter int CW          = 8,
	parameter int RW          = 9
) (
	input  logic          clk,
	input  pt_t           px,
	input  pt_t           py,
	input  logic [CW-1:0] c,
	input  logic [RW-1:0] r,
	input  logic          r_neg,
	output logic          hit
);

	localparam int XMAX = GAP_X + CELL_WIDTH + SLANT_WIDTH + PAIR_PITCH * ((1 << CW) / 2)
		+ SIDE_LEN + SLANT_WIDTH + (1 << PT_W);
	localparam int YMAX = ((1 << RW) - 1) * ROW_STEP + CELL_HEIGHT + (1 << PT_W);
	localparam int XW   = $clog2(XMAX + 1);
	localparam int YW   = $clog2(YMAX + 1);
	localparam int LW   = $clog2(SLANT_WIDTH + 1);
	localparam int DW   = $clog2(CELL_HEIGHT + 1);

	logic [LW-1:0]   lim_rom [CELL_HEIGHT+1];

	logic            ok;
	logic [CW-1:0]   cm;
	logic [XW-1:0]   x0;
	logic [YW-1:0]   y0;

	logic            ok_s4;
	logic [XW-1:0]   x0_s4;
	logic [YW-1:0]   y0_s4;
	pt_t             px_s4;
	pt_t             py_s4;

	logic [YW-1:0]   pyw;
	logic [YW-1:0]   ytop;
	logic [YW-1:0]   dyw;
	logic            vert;
	logic [DW-1:0]   dy_idx;

	logic            vert_s5;
	logic [LW-1:0]   lim_s5;
	logic [XW-1:0]   x0_s5;
	pt_t             px_s5;

	logic [XW-1:0]   pxw;
	logic [XW-1:0]   limw;

	// side slope: SLANT_WIDTH * min(dy, H - dy) / (H / 2)
	for (genvar g = 0; g <= CELL_HEIGHT; g++) begin : g_lim
		localparam int MD = (g < CELL_HEIGHT - g) ? g : CELL_HEIGHT - g;
		localparam int LV = SLANT_WIDTH * MD / (CELL_HEIGHT / 2);
		assign lim_rom[g] = LW'(LV);
	end

	// negative row, or odd column on row 0, is not a cell
	assign ok = !r_neg && !(c[0] && (r == '0));
	assign cm = c >> 1;
	assign x0 = (c[0] ? XW'(GAP_X + CELL_WIDTH) : XW'(SLANT_WIDTH))
		+ XW'(XW'(cm) * XW'(PAIR_PITCH));
	assign y0 = YW'(YW'(r) * YW'(ROW_STEP));

	always_ff @(posedge clk) begin
		ok_s4 <= ok;
		x0_s4 <= x0;
		y0_s4 <= y0;
		px_s4 <= px;
		py_s4 <= py;
	end

	assign pyw    = YW'(py_s4);
	assign ytop   = y0_s4 + YW'(CELL_HEIGHT);
	assign vert   = ok_s4 && (pyw >= y0_s4) && (pyw <= ytop);
	assign dyw    = pyw - y0_s4;
	assign dy_idx = vert ? DW'(dyw) : '0;

	always_ff @(posedge clk) begin
		vert_s5 <= vert;
		lim_s5  <= lim_rom[dy_idx];
		x0_s5   <= x0_s4;
		px_s5   <= px_s4;
	end

	assign pxw  = XW'(px_s5);
	assign limw = XW'(lim_s5);
	assign hit  = vert_s5 && (pxw + limw >= x0_s5)
		&& (pxw <= x0_s5 + XW'(SIDE_LEN) + limw);

endmodule

`default_nettype wire

// File: rtl/pixel_to_hex_cell_locator.sv
// An accepted request passes the input register, the reciprocal-multiply divider (two stages),
// the per-candidate vertex and side-slope tests (two stages) and the result register before
// its done strobe. Throughput: one request per cycle, busy is always low;
// receiver cannot stall.
// Reset clears the valid pipeline and done; payload registers are not reset.
`default_nettype none
`include "pixel_to_hex_cell_locator_macros.svh"

module pixel_to_hex_cell_locator import p2h_pkg::*; #(
	parameter int SIDE_LEN    = 20,
	parameter int SLANT_WIDTH = 10,
	parameter int CELL_HEIGHT = 34,
	parameter int GAP_X       = 2,
	parameter int GAP_Y       = 2,
	parameter int CELL_WIDTH  = 40
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  pt_t  point_x,
	input  pt_t  point_y,
	output logic done,
	output logic found,
	output idx_t hex_column,
	output idx_t hex_row
);

	localparam int COL_PITCH  = 3 * SLANT_WIDTH + GAP_X;
	localparam int ROW_PITCH  = CELL_HEIGHT + GAP_Y;
	localparam int PAIR_PITCH = 2 * GAP_X + SIDE_LEN + CELL_WIDTH;
	localparam int ROW_STEP   = GAP_Y - 1 + CELL_HEIGHT / 2;
	localparam int Y_OFS      = CELL_HEIGHT / 2 + GAP_Y;
	localparam int GC_MAX     = ((1 << PT_W) - 1 - SLANT_WIDTH) / COL_PITCH;
	localparam int CW         = $clog2(GC_MAX + 2);
	localparam int QY         = $clog2(((1 << PT_W) - 1) / ROW_PITCH + 1);
	localparam int RW         = QY + 2;

	logic            accept;
	logic            v_s1, v_s2, v_s3, v_s4, v_s5;
	pt_t             px_s1, py_s1, px_s2, py_s2, px_s3, py_s3;

	logic [CW-1:0]   gc_s3;
	logic [QY:0]     gr_s3;
	logic [CW-1:0]   c1_s3;
	logic [RW-1:0]   r0_s3, r1_s3, r2_s3;
	logic            r2_neg_s3;

	logic [CW-1:0]   gc_s4, gc_s5;
	logic [RW-1:0]   gr_s4, gr_s5;
	logic [CW-1:0]   c1_s5;
	logic [RW-1:0]   r1_s5, r2_s5;
	logic [2:0]      hit;

	idx_t            col0_idx, col1_idx;
	logic            done_q, found_q;
	idx_t            col_q, row_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= accept;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			done_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1 <= point_x;
			py_s1 <= point_y;
		end
		px_s2 <= px_s1;
		py_s2 <= py_s1;
		px_s3 <= px_s2;
		py_s3 <= py_s2;
		gc_s4 <= gc_s3;
		gr_s4 <= r0_s3;
		gc_s5 <= gc_s4;
		gr_s5 <= gr_s4;
	end

	p2h_guess #(
		.SIDE_LEN    (SIDE_LEN),
		.SLANT_WIDTH (SLANT_WIDTH),
		.COL_PITCH   (COL_PITCH),
		.ROW_PITCH   (ROW_PITCH),
		.Y_OFS       (Y_OFS),
		.CW          (CW),
		.QY          (QY)
	) u_guess (
		.clk (clk),
		.px  (px_s1),
		.py  (py_s1),
		.gc  (gc_s3),
		.gr  (gr_s3)
	);

	// candidates in test order: guess, upper right, lower right
	assign c1_s3     = gc_s3 + 1'b1;
	assign r0_s3     = RW'(gr_s3);
	assign r1_s3     = r0_s3 + 1'b1;
	assign r2_s3     = r0_s3 - 1'b1;
	assign r2_neg_s3 = (gr_s3 == '0);

	p2h_cand #(
		.SIDE_LEN (SIDE_LEN), .SLANT_WIDTH (SLANT_WIDTH), .CELL_HEIGHT (CELL_HEIGHT),
		.GAP_X (GAP_X), .CELL_WIDTH (CELL_WIDTH), .PAIR_PITCH (PAIR_PITCH),
		.ROW_STEP (ROW_STEP), .CW (CW), .RW (RW)
	) u_cand0 (
		.clk (clk), .px (px_s3), .py (py_s3),
		.c (gc_s3), .r (r0_s3), .r_neg (1'b0), .hit (hit[0])
	);

	p2h_cand #(
		.SIDE_LEN (SIDE_LEN), .SLANT_WIDTH (SLANT_WIDTH), .CELL_HEIGHT (CELL_HEIGHT),
		.GAP_X (GAP_X), .CELL_WIDTH (CELL_WIDTH), .PAIR_PITCH (PAIR_PITCH),
		.ROW_STEP (ROW_STEP), .CW (CW), .RW (RW)
	) u_cand1 (
		.clk (clk), .px (px_s3), .py (py_s3),
		.c (c1_s3), .r (r1_s3), .r_neg (1'b0), .hit (hit[1])
	);

	p2h_cand #(
		.SIDE_LEN (SIDE_LEN), .SLANT_WIDTH (SLANT_WIDTH), .CELL_HEIGHT (CELL_HEIGHT),
		.GAP_X (GAP_X), .CELL_WIDTH (CELL_WIDTH), .PAIR_PITCH (PAIR_PITCH),
		.ROW_STEP (ROW_STEP), .CW (CW), .RW (RW)
	) u_cand2 (
		.clk (clk), .px (px_s3), .py (py_s3),
		.c (c1_s3), .r (r2_s3), .r_neg (r2_neg_s3), .hit (hit[2])
	);

	assign c1_s5    = gc_s5 + 1'b1;
	assign r1_s5    = gr_s5 + 1'b1;
	assign r2_s5    = gr_s5 - 1'b1;
	assign col0_idx = IDX_W'(gc_s5);
	assign col1_idx = IDX_W'(c1_s5);

	// first hit wins; indices are zero-extended to the reported width
	always_ff @(posedge clk) begin
		found_q <= |hit;
		if (hit[0]) begin
			col_q <= col0_idx;
			row_q <= IDX_W'(gr_s5);
		end else if (hit[1]) begin
			col_q <= col1_idx;
			row_q <= IDX_W'(r1_s5);
		end else if (hit[2]) begin
			col_q <= col1_idx;
			row_q <= IDX_W'(r2_s5);
		end else begin
			col_q <= '0;
			row_q <= '0;
		end
	end

	assign done       = done_q;
	assign found      = found_q;
	assign hex_column = col_q;
	assign hex_row    = row_q;

	// the assertion samples done before each edge, so it sees done high from the edge after the one that sets it
	`P2H_ASSERT(a_latency, accept |-> ##6 done, "request did not complete at fixed latency")
	`P2H_ASSERT(a_miss_zero, done && !found |-> hex_column == '0 && hex_row == '0, "miss with nonzero index")
	`P2H_ASSERT_NEXT(a_hit_col, v_s5 && (|hit), found && (hex_column == $past(col0_idx) || hex_column == $past(col1_idx)), "hit column not from guess")

endmodule

`default_nettype wire

// File: sim/tb_pixel_to_hex_cell_locator.sv
// Testbench for the pixel to hex cell locator: directed and random point queries checked against a predictor.
`default_nettype none

module tb_pixel_to_hex_cell_locator;
	import p2h_pkg::*;

	localparam int SIDE_LEN    = 20;
	localparam int SLANT_WIDTH = 10;
	localparam int CELL_HEIGHT = 34;
	localparam int GAP_X       = 2;
	localparam int GAP_Y       = 2;
	localparam int CELL_WIDTH  = 40;

	localparam int COL_PITCH  = 3 * SLANT_WIDTH + GAP_X;
	localparam int ROW_PITCH  = CELL_HEIGHT + GAP_Y;
	localparam int PAIR_PITCH = 2 * GAP_X + SIDE_LEN + CELL_WIDTH;
	localparam int HALF_H     = CELL_HEIGHT / 2;
	localparam int ROW_STEP   = GAP_Y - 1 + CELL_HEIGHT / 2;
	localparam int PT_MAX     = (1 << PT_W) - 1;

	localparam int LATENCY    = 5;
	localparam int STALL_LIMIT = 1000;

	typedef struct packed {
		logic found;
		idx_t col;
		idx_t row;
	} hex_hit_t;

	logic clk;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	pt_t  point_x = '0;
	pt_t  point_y = '0;
	logic busy;
	logic done;
	logic found;
	idx_t hex_column;
	idx_t hex_row;

	hex_hit_t pending_hits[$];
	int mismatches = 0;
	int stall_cycles = 0;
	bit idle_on = 1'b1;

	pixel_to_hex_cell_locator #(
		.SIDE_LEN(SIDE_LEN),
		.SLANT_WIDTH(SLANT_WIDTH),
		.CELL_HEIGHT(CELL_HEIGHT),
		.GAP_X(GAP_X),
		.GAP_Y(GAP_Y),
		.CELL_WIDTH(CELL_WIDTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.point_x(point_x),
		.point_y(point_y),
		.done(done),
		.found(found),
		.hex_column(hex_column),
		.hex_row(hex_row)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------- grid predictor ----------------

	function automatic int slope_limit(int dy);
		int m;
		m = CELL_HEIGHT - dy;
		if (dy < m) m = dy;
		return (SLANT_WIDTH * m) / HALF_H;
	endfunction

	// x of the lower-left vertex of a cell
	function automatic int cell_left_x(int c);
		if (c[0]) return GAP_X + CELL_WIDTH + (PAIR_PITCH * (c - 1)) / 2;
		return SLANT_WIDTH + (PAIR_PITCH * c) / 2;
	endfunction

	function automatic bit cell_contains(int px, int py, int c, int r);
		int x0;
		int y0;
		int lim;
		if (c < 0 || r < 0) return 1'b0;
		if (c[0] && r < 1) return 1'b0;
		x0 = cell_left_x(c);
		y0 = r * ROW_STEP;
		if (py < y0 || py > y0 + CELL_HEIGHT) return 1'b0;
		lim = slope_limit(py - y0);
		if (px < x0 - lim || px > x0 + SIDE_LEN + lim) return 1'b0;
		return 1'b1;
	endfunction

	function automatic hex_hit_t locate_hex(pt_t x, pt_t y);
		int px;
		int py;
		int gc;
		int gr;
		int num;
		int cc[3];
		int cr[3];
		hex_hit_t hit;
		px = x;
		py = y;
		if (px < SIDE_LEN + SLANT_WIDTH) gc = 0;
		else gc = (px - SLANT_WIDTH) / COL_PITCH;
		if (gc[0]) begin
			// odd columns sit half a row up; clamp so low points guess row 1
			num = py - HALF_H - GAP_Y;
			if (num < 0) num = 0;
			gr = 1 + 2 * (num / ROW_PITCH);
		end else begin
			gr = 2 * (py / ROW_PITCH);
		end
		cc[0] = gc;     cr[0] = gr;
		cc[1] = gc + 1; cr[1] = gr + 1;
		cc[2] = gc + 1; cr[2] = gr - 1;
		hit = '0;
		for (int k = 0; k < 3; k++) begin
			if (cell_contains(px, py, cc[k], cr[k])) begin
				hit.found = 1'b1;
				hit.col = idx_t'(cc[k]);
				hit.row = idx_t'(cr[k]);
				return hit;
			end
		end
		return hit;
	endfunction

	// ---------------- checking ----------------

	task automatic report_mismatch(input string what, input int exp_v, input int got_v);
		$display("MISMATCH at %0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
		mismatches++;
	endtask

	always @(posedge clk) begin
		hex_hit_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_hits.size() == 0) begin
				report_mismatch("result with no request pending, column", 0, hex_column);
			end else begin
				want = pending_hits.pop_front();
				if (found !== want.found) report_mismatch("found", want.found, found);
				if (hex_column !== want.col) report_mismatch("hex_column", want.col, hex_column);
				if (hex_row !== want.row) report_mismatch("hex_row", want.row, hex_row);
			end
		end
	end

	// watchdog: cycles with neither a request nor a result accepted
	always @(posedge clk) begin
		if ((start && !busy) || done === 1'b1) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// ---------------- stimulus ----------------

	task automatic send_point(input int x, input int y);
		if (x < 0) x = 0;
		if (x > PT_MAX) x = PT_MAX;
		if (y < 0) y = 0;
		if (y > PT_MAX) y = PT_MAX;
		while (idle_on && $urandom_range(0, 99) < 27) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		point_x <= pt_t'(x);
		point_y <= pt_t'(y);
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_hits.push_back(locate_hex(pt_t'(x), pt_t'(y)));
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_hits.size() != 0) @(posedge clk);
	endtask

	task automatic test_extremes();
		send_point(0, 0);          // miss in the left margin, row below zero rejected
		send_point(PT_MAX, PT_MAX);
		send_point(PT_MAX, 0);
		send_point(0, PT_MAX);
		send_point('hAAA, 'h555);
		send_point('h555, 'hAAA);
	endtask

	task automatic test_left_margin();
		send_point(SIDE_LEN + SLANT_WIDTH - 1, 10);
		send_point(SIDE_LEN + SLANT_WIDTH, 10);
	endtask

	task automatic test_low_odd_row();
		send_point(50, 5);   // odd guessed column, nothing underneath
		send_point(50, 20);  // odd guessed column, first odd row hit
		send_point(60, 0);
	endtask

	// edges of a few cells: just inside left slope, just outside right, top edge
	task automatic test_cell_edges();
		int cols[5] = '{0, 1, 2, 5, 126};
		int rows[5] = '{0, 1, 4, 7, 224};
		int x0;
		int y0;
		for (int i = 0; i < 5; i++) begin
			x0 = cell_left_x(cols[i]);
			y0 = rows[i] * ROW_STEP;
			send_point(x0 - SLANT_WIDTH, y0 + HALF_H);
			send_point(x0 + SIDE_LEN + SLANT_WIDTH + 1, y0 + HALF_H);
			send_point(x0 + SIDE_LEN / 2, y0 + CELL_HEIGHT);
		end
	endtask

	task automatic test_random_points(input int count);
		int c;
		int r;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 60) begin
				// aim near a real cell so all three candidates see hits
				c = $urandom_range(0, 127);
				r = 2 * $urandom_range(0, 113) + c[0];
				send_point(cell_left_x(c) - SLANT_WIDTH - 2
						+ $urandom_range(0, SIDE_LEN + 2 * SLANT_WIDTH + 4),
					r * ROW_STEP - 1 + $urandom_range(0, CELL_HEIGHT + 2));
			end else begin
				send_point($urandom_range(0, PT_MAX), $urandom_range(0, PT_MAX));
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_left_margin();
		test_low_odd_row();
		test_cell_edges();

		test_random_points(180);
		idle_on = 1'b0;
		test_random_points(120);
		idle_on = 1'b1;
		wait_for_results();
		test_random_points(250);

		wait_for_results();
		repeat (LATENCY + 5) @(posedge clk);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
+incdir+rtl
rtl/p2h_pkg.sv
rtl/p2h_cdiv.sv
rtl/p2h_guess.sv
rtl/p2h_cand.sv
rtl/pixel_to_hex_cell_locator.sv
sim/tb_pixel_to_hex_cell_locator.sv
